>>> rtl/lcs_pkg.sv
// Shared constants, types and helpers for the longest-common-subsequence block.
package lcs_pkg;

  // Longest string held; each string and the result stack hold this many bytes
  localparam int unsigned MAX_LEN   = 32;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned OUT_LEN_W = 6;

  // Counter width able to hold MAX_LEN itself, and index width into a string
  localparam int unsigned LEN_W     = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // Score table holds rows and columns one and up only; row and column zero read as zero
  localparam int unsigned TBL_DEPTH = MAX_LEN * MAX_LEN;
  localparam int unsigned TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  // Request command codes
  localparam logic [CMD_W-1:0] CmdAppendFirst  = 2'd0;
  localparam logic [CMD_W-1:0] CmdAppendSecond = 2'd1;
  localparam logic [CMD_W-1:0] CmdRun          = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_BUBBLE,
    S_DRAIN,
    S_TR_UP,
    S_TR_LEFT,
    S_TR_DEC,
    S_EMIT_RD,
    S_EMIT_LD
  } lcs_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic run_start;
    logic append_first;
    logic append_second;
    logic fill_issue;
    logic tr_issue_up;
    logic tr_issue_left;
    logic tr_decide;
    logic emit_read;
    logic emit_load;
    logic finish;
  } lcs_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty_run;
    logic fill_row_end;
    logic fill_last;
    logic trace_done;
    logic out_free;
    logic emit_last;
  } lcs_sts_t;

  // Flat address of score cell (row, col), both counted from one and given minus one
  function automatic logic [TBL_AW-1:0] tbl_addr(logic [IDX_W-1:0] row_m1,
                                                 logic [IDX_W-1:0] col_m1);
    int unsigned flat;
    flat = int'(row_m1) * MAX_LEN + int'(col_m1);
    return TBL_AW'(flat);
  endfunction

endpackage

>>> rtl/lcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lcs_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while no read is enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lcs_ctrl.sv
// Controller state machine: loading, table fill, traceback and emission sequencing.
module lcs_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  input  logic [lcs_pkg::CMD_W-1:0]   command_i,
  output logic                        s_ready_o,
  input  lcs_pkg::lcs_sts_t           sts_i,
  output lcs_pkg::lcs_ctl_t           ctl_o
);

  lcs_pkg::lcs_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcs_pkg::S_IDLE: begin
        if (s_valid_i && (command_i == lcs_pkg::CmdRun)) begin
          state_d = sts_i.empty_run ? lcs_pkg::S_TR_UP : lcs_pkg::S_FILL;
        end
      end
      lcs_pkg::S_FILL: begin
        if (sts_i.fill_last) begin
          state_d = lcs_pkg::S_DRAIN;
        end else if (sts_i.fill_row_end) begin
          state_d = lcs_pkg::S_BUBBLE;
        end
      end
      lcs_pkg::S_BUBBLE:  state_d = lcs_pkg::S_FILL;
      lcs_pkg::S_DRAIN:   state_d = lcs_pkg::S_TR_UP;
      lcs_pkg::S_TR_UP: begin
        state_d = sts_i.trace_done ? lcs_pkg::S_EMIT_RD : lcs_pkg::S_TR_LEFT;
      end
      lcs_pkg::S_TR_LEFT: state_d = lcs_pkg::S_TR_DEC;
      lcs_pkg::S_TR_DEC:  state_d = lcs_pkg::S_TR_UP;
      lcs_pkg::S_EMIT_RD: state_d = lcs_pkg::S_EMIT_LD;
      lcs_pkg::S_EMIT_LD: begin
        if (sts_i.out_free) begin
          state_d = sts_i.emit_last ? lcs_pkg::S_IDLE : lcs_pkg::S_EMIT_RD;
        end
      end
      default: state_d = lcs_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    ctl_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      lcs_pkg::S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          case (command_i)
            lcs_pkg::CmdAppendFirst:  ctl_o.append_first  = 1'b1;
            lcs_pkg::CmdAppendSecond: ctl_o.append_second = 1'b1;
            lcs_pkg::CmdRun:          ctl_o.run_start     = 1'b1;
            default: ;
          endcase
        end
      end
      lcs_pkg::S_FILL:    ctl_o.fill_issue = 1'b1;
      lcs_pkg::S_BUBBLE:  ;
      lcs_pkg::S_DRAIN:   ;
      lcs_pkg::S_TR_UP:   ctl_o.tr_issue_up = !sts_i.trace_done;
      lcs_pkg::S_TR_LEFT: ctl_o.tr_issue_left = 1'b1;
      lcs_pkg::S_TR_DEC:  ctl_o.tr_decide = 1'b1;
      lcs_pkg::S_EMIT_RD: ctl_o.emit_read = 1'b1;
      lcs_pkg::S_EMIT_LD: begin
        if (sts_i.out_free) begin
          ctl_o.emit_load = 1'b1;
          ctl_o.finish    = sts_i.emit_last;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/lcs_dp.sv
// Datapath: string stores, score table fill pipeline, traceback, result stack, output register.
module lcs_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [lcs_pkg::SYM_W-1:0]       symbol_i,
  input  lcs_pkg::lcs_ctl_t               ctl_i,
  output lcs_pkg::lcs_sts_t               sts_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lcs_pkg::SYM_W-1:0]       lcs_char_o,
  output logic [lcs_pkg::OUT_LEN_W-1:0]   lcs_length_o,
  output logic                            is_empty_o,
  output logic                            overflow_o,
  output logic                            last_o
);

  localparam int unsigned LW = lcs_pkg::LEN_W;
  localparam int unsigned IW = lcs_pkg::IDX_W;
  localparam int unsigned AW = lcs_pkg::TBL_AW;
  localparam int unsigned SW = lcs_pkg::SYM_W;

  localparam logic [LW-1:0] One    = LW'(1);
  localparam logic [LW-1:0] Two    = LW'(2);
  localparam logic [LW-1:0] MaxLen = LW'(lcs_pkg::MAX_LEN);

  // Loading state
  logic [LW-1:0] len_a_q, len_b_q;
  logic          dropped_q;

  // Fill counters and capture stage
  logic [LW-1:0] fi_q, fj_q;
  logic          p1_valid_q;
  logic [LW-1:0] p1_i_q, p1_j_q;
  logic [LW-1:0] left_q, prev_up_q;

  // Traceback state
  logic [LW-1:0] ti_q, tj_q, depth_q, up_q;
  logic [LW-1:0] emit_k_q;

  // Output register
  logic          out_valid_q;
  logic [SW-1:0] out_char_q;
  logic [LW-1:0] out_len_q;
  logic          out_empty_q, out_ovf_q, out_last_q;

  // Memory ports
  logic          str_re;
  logic [IW-1:0] stra_raddr, strb_raddr;
  logic [SW-1:0] stra_rdata, strb_rdata;
  logic          tbl_re, tbl_we;
  logic [AW-1:0] tbl_raddr, tbl_waddr;
  logic [LW-1:0] tbl_rdata, tbl_wdata;
  logic          stk_we;
  logic [IW-1:0] stk_raddr;
  logic [SW-1:0] stk_rdata;

  // Fill compute
  logic [LW-1:0] f_up, f_left, f_diag, f_val;
  logic          f_match;

  // Traceback compute
  logic [LW-1:0] t_left;
  logic          t_match;

  // Status
  logic fill_row_end, emit_last, out_free;

  assign fill_row_end = (fj_q == len_b_q);
  assign emit_last    = (depth_q == '0) || (emit_k_q == depth_q - One);
  assign out_free     = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o              = '0;
    sts_o.empty_run    = (len_a_q == '0) || (len_b_q == '0);
    sts_o.fill_row_end = fill_row_end;
    sts_o.fill_last    = fill_row_end && (fi_q == len_a_q);
    sts_o.trace_done   = (ti_q == '0) || (tj_q == '0);
    sts_o.out_free     = out_free;
    sts_o.emit_last    = emit_last;
  end

  // Read address selection for strings and table
  always_comb begin
    str_re     = ctl_i.fill_issue || ctl_i.tr_issue_up;
    stra_raddr = ctl_i.fill_issue ? IW'(fi_q - One) : IW'(ti_q - One);
    strb_raddr = ctl_i.fill_issue ? IW'(fj_q - One) : IW'(tj_q - One);
    tbl_re     = ctl_i.fill_issue || ctl_i.tr_issue_up || ctl_i.tr_issue_left;
    if (ctl_i.fill_issue) begin
      tbl_raddr = lcs_pkg::tbl_addr(IW'(fi_q - Two), IW'(fj_q - One));
    end else if (ctl_i.tr_issue_up) begin
      tbl_raddr = lcs_pkg::tbl_addr(IW'(ti_q - Two), IW'(tj_q - One));
    end else begin
      tbl_raddr = lcs_pkg::tbl_addr(IW'(ti_q - One), IW'(tj_q - Two));
    end
  end

  // Score of the cell in the capture stage
  always_comb begin
    f_up      = (p1_i_q == One) ? '0 : tbl_rdata;
    f_diag    = (p1_j_q == One) ? '0 : prev_up_q;
    f_left    = (p1_j_q == One) ? '0 : left_q;
    f_match   = (stra_rdata == strb_rdata);
    f_val     = f_match ? f_diag + One : ((f_up > f_left) ? f_up : f_left);
    tbl_we    = p1_valid_q;
    tbl_waddr = lcs_pkg::tbl_addr(IW'(p1_i_q - One), IW'(p1_j_q - One));
    tbl_wdata = f_val;
  end

  // Traceback decision inputs
  assign t_left    = (tj_q > One) ? tbl_rdata : '0;
  assign t_match   = (stra_rdata == strb_rdata);
  assign stk_we    = ctl_i.tr_decide && t_match && (depth_q < MaxLen);
  assign stk_raddr = IW'(depth_q - One - emit_k_q);

  // Loading lengths and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_a_q   <= '0;
      len_b_q   <= '0;
      dropped_q <= 1'b0;
    end else if (ctl_i.finish) begin
      len_a_q   <= '0;
      len_b_q   <= '0;
      dropped_q <= 1'b0;
    end else if (ctl_i.append_first) begin
      if (len_a_q < MaxLen) begin
        len_a_q <= len_a_q + One;
      end else begin
        dropped_q <= 1'b1;
      end
    end else if (ctl_i.append_second) begin
      if (len_b_q < MaxLen) begin
        len_b_q <= len_b_q + One;
      end else begin
        dropped_q <= 1'b1;
      end
    end
  end

  // Fill counters and capture stage; wrap the column at the end of each row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fi_q       <= '0;
      fj_q       <= '0;
      p1_valid_q <= 1'b0;
      p1_i_q     <= '0;
      p1_j_q     <= '0;
      left_q     <= '0;
      prev_up_q  <= '0;
    end else begin
      p1_valid_q <= ctl_i.fill_issue;
      if (ctl_i.run_start) begin
        fi_q <= One;
        fj_q <= One;
      end else if (ctl_i.fill_issue) begin
        p1_i_q <= fi_q;
        p1_j_q <= fj_q;
        if (fill_row_end) begin
          fj_q <= One;
          fi_q <= fi_q + One;
        end else begin
          fj_q <= fj_q + One;
        end
      end
      if (p1_valid_q) begin
        left_q    <= f_val;
        prev_up_q <= f_up;
      end
    end
  end

  // Traceback walk and result depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ti_q     <= '0;
      tj_q     <= '0;
      depth_q  <= '0;
      up_q     <= '0;
      emit_k_q <= '0;
    end else begin
      if (ctl_i.run_start) begin
        ti_q     <= len_a_q;
        tj_q     <= len_b_q;
        depth_q  <= '0;
        emit_k_q <= '0;
      end
      if (ctl_i.tr_issue_left) begin
        up_q <= (ti_q > One) ? tbl_rdata : '0;
      end
      if (ctl_i.tr_decide) begin
        if (t_match) begin
          if (depth_q < MaxLen) begin
            depth_q <= depth_q + One;
          end
          ti_q <= ti_q - One;
          tj_q <= tj_q - One;
        end else if (up_q > t_left) begin
          ti_q <= ti_q - One;
        end else begin
          tj_q <= tj_q - One;
        end
      end
      if (ctl_i.emit_load) begin
        emit_k_q <= emit_k_q + One;
      end
    end
  end

  // Output register: hold until taken, load the next result when free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_load) begin
      out_char_q  <= (depth_q == '0) ? '0 : stk_rdata;
      out_len_q   <= depth_q;
      out_empty_q <= (depth_q == '0);
      out_ovf_q   <= dropped_q;
      out_last_q  <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign lcs_char_o   = out_char_q;
  assign lcs_length_o = lcs_pkg::OUT_LEN_W'(out_len_q);
  assign is_empty_o   = out_empty_q;
  assign overflow_o   = out_ovf_q;
  assign last_o       = out_last_q;

  // First string
  lcs_ram #(.WIDTH(SW), .DEPTH(lcs_pkg::MAX_LEN), .ADDR_W(IW)) u_str_a (
    .clk_i   (clk_i),
    .we_i    (ctl_i.append_first && (len_a_q < MaxLen)),
    .waddr_i (IW'(len_a_q)),
    .wdata_i (symbol_i),
    .re_i    (str_re),
    .raddr_i (stra_raddr),
    .rdata_o (stra_rdata)
  );

  // Second string
  lcs_ram #(.WIDTH(SW), .DEPTH(lcs_pkg::MAX_LEN), .ADDR_W(IW)) u_str_b (
    .clk_i   (clk_i),
    .we_i    (ctl_i.append_second && (len_b_q < MaxLen)),
    .waddr_i (IW'(len_b_q)),
    .wdata_i (symbol_i),
    .re_i    (str_re),
    .raddr_i (strb_raddr),
    .rdata_o (strb_rdata)
  );

  // Score table
  lcs_ram #(.WIDTH(LW), .DEPTH(lcs_pkg::TBL_DEPTH), .ADDR_W(AW)) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Result stack, pushed during traceback and popped during emission
  lcs_ram #(.WIDTH(SW), .DEPTH(lcs_pkg::MAX_LEN), .ADDR_W(IW)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (IW'(depth_q)),
    .wdata_i (stra_rdata),
    .re_i    (ctl_i.emit_read),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

endmodule

>>> rtl/lcs_table_and_traceback_top.sv
// Top level of the longest-common-subsequence block: controller and datapath.
//
// Requests arrive on the s_axis channel: tuser carries the command (append to
// the first string, append to the second string, run) and tdata the byte.
// Bytes beyond 32 per string are dropped and flagged.
// A run fills the score table one cell per cycle with a bubble state between
// rows, then walks back from the far corner, reading up, reading left and
// deciding at each step (two table reads on the single read port of the table
// memory), then emits the subsequence first to last on m_axis, reading and
// then loading each result.
// An empty subsequence gives one result flagged empty. After the last result
// is loaded the strings and the overflow flag are cleared and new requests are
// taken while that result still waits in the output register.
// A stalled receiver holds the current result and pauses emission.
// Reset clears lengths, flag and control; memories need no clearing.
module lcs_table_and_traceback_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] lcs_char, [13:8] lcs_length, [15:14] zero
  output logic [1:0]  m_axis_tuser,   // [0] is_empty, [1] overflow
  output logic        m_axis_tlast    // last
);

  lcs_pkg::lcs_ctl_t ctl;
  lcs_pkg::lcs_sts_t sts;

  logic [lcs_pkg::SYM_W-1:0]     lcs_char;
  logic [lcs_pkg::OUT_LEN_W-1:0] lcs_length;
  logic                          is_empty, overflow;

  lcs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .command_i (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  lcs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .symbol_i     (s_axis_tdata),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .lcs_char_o   (lcs_char),
    .lcs_length_o (lcs_length),
    .is_empty_o   (is_empty),
    .overflow_o   (overflow),
    .last_o       (m_axis_tlast)
  );

  // Pack result fields onto the stream
  assign m_axis_tdata = {2'b00, lcs_length, lcs_char};
  assign m_axis_tuser = {overflow, is_empty};

endmodule
